/* rtl/core/irsg_pkg.sv */
// Shared types and constants for the integer range sequence generator.
// Used by irsg_ctrl, irsg_dp, the top level and the port checker.
`timescale 1ns / 1ps

package irsg_pkg;

	// Operand and element width
	localparam int unsigned DATA_W = 64;
	// Divider iteration counter width (one quotient bit per cycle)
	localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

	// Result status codes
	typedef enum logic [1:0] {
		ST_ELEMENT  = 2'd0,
		ST_NULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_TOO_LONG = 2'd3
	} stat_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_EVAL,
		S_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic  capture;    // load request operands
		logic  div_load;   // load divider with |end-start| and |step|
		logic  div_step;   // one restoring division step
		logic  seq_load;   // load first element and list length
		logic  push_elem;  // place next element into the output register
		logic  push_stat;  // place a status-only result into the output register
		stat_t stat_code;  // code for push_stat
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic  out_free;   // output register can take a result this cycle
		logic  chk_special;// request resolves without division
		stat_t chk_code;
		logic  div_done;   // final division step in progress
		logic  eval_bad;   // length out of range or zero
		stat_t eval_code;
		logic  elem_last;  // element being pushed is the last one
	} sts_t;

endpackage

/* rtl/core/irsg_ctrl.sv */
// Sequencing state machine for the range generator.
// Depends on irsg_pkg (state_t, cmd_t, sts_t).
`timescale 1ns / 1ps

module irsg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  irsg_pkg::sts_t sts,
	output irsg_pkg::cmd_t cmd
);

	irsg_pkg::state_t state_q;
	irsg_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irsg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.stat_code = irsg_pkg::ST_EMPTY;
		case (state_q)
			irsg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = irsg_pkg::S_CHECK;
				end
			end
			irsg_pkg::S_CHECK: begin
				if (sts.chk_special) begin
					cmd.stat_code = sts.chk_code;
					if (sts.out_free) begin
						cmd.push_stat = 1'b1;
						state_d       = irsg_pkg::S_IDLE;
					end
				end else begin
					cmd.div_load = 1'b1;
					state_d      = irsg_pkg::S_DIV;
				end
			end
			irsg_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = irsg_pkg::S_EVAL;
				end
			end
			irsg_pkg::S_EVAL: begin
				if (sts.eval_bad) begin
					cmd.stat_code = sts.eval_code;
					if (sts.out_free) begin
						cmd.push_stat = 1'b1;
						state_d       = irsg_pkg::S_IDLE;
					end
				end else begin
					cmd.seq_load = 1'b1;
					state_d      = irsg_pkg::S_EMIT;
				end
			end
			irsg_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.push_elem = 1'b1;
					if (sts.elem_last) begin
						state_d = irsg_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = irsg_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/irsg_dp.sv */
// Datapath: operand registers, range checks, radix-2 divider, element
// generator and output register. Depends on irsg_pkg.
`timescale 1ns / 1ps

module irsg_dp #(
	parameter int unsigned MAX_LIST_LEN = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic signed [irsg_pkg::DATA_W-1:0] start_val,
	input  logic signed [irsg_pkg::DATA_W-1:0] end_val,
	input  logic signed [irsg_pkg::DATA_W-1:0] step_val,
	input  logic                               any_null,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [irsg_pkg::DATA_W-1:0] element,
	output logic [1:0]                         status,
	output logic                               last,
	input  irsg_pkg::cmd_t                     cmd,
	output irsg_pkg::sts_t                     sts
);

	localparam int unsigned DW    = irsg_pkg::DATA_W;
	localparam int unsigned CW    = irsg_pkg::DIV_CNT_W;
	// Holds list lengths up to MAX_LIST_LEN + 1
	localparam int unsigned LEN_W = $clog2(MAX_LIST_LEN + 2);

	logic                 incl_q;
	logic [DW-1:0]        start_q;
	logic [DW-1:0]        end_q;
	logic [DW-1:0]        step_q;
	logic                 null_q;
	logic [DW-1:0]        mag_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        quo_q;
	logic [CW-1:0]        cnt_q;
	logic [DW-1:0]        cur_q;
	logic [LEN_W-1:0]     left_q;
	logic                 ov_q;
	logic [DW-1:0]        elem_q;
	irsg_pkg::stat_t      stat_q;
	logic                 last_q;

	logic                 end_lt_start;
	logic                 start_lt_end;
	logic [DW-1:0]        diff;
	logic [DW-1:0]        mag;
	logic [DW:0]          trial;
	logic [DW:0]          trial_sub;
	logic                 q_big;
	logic [LEN_W-1:0]     len;
	logic                 len_big;
	logic                 chk_special;
	irsg_pkg::stat_t      chk_code;
	logic                 eval_bad;
	irsg_pkg::stat_t      eval_code;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incl_q <= 1'b0;
		end else if (cfg_we) begin
			incl_q <= cfg_wdata;
		end
	end

	// Operand capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			start_q <= start_val;
			end_q   <= end_val;
			step_q  <= step_val;
			null_q  <= any_null;
		end
	end

	// Special cases: null, zero step, wrong direction
	always_comb begin
		end_lt_start = $signed(end_q) < $signed(start_q);
		start_lt_end = $signed(start_q) < $signed(end_q);
		chk_special  = 1'b1;
		chk_code     = irsg_pkg::ST_EMPTY;
		if (null_q) begin
			chk_code = irsg_pkg::ST_NULL;
		end else if (step_q == '0) begin
			chk_code = irsg_pkg::ST_EMPTY;
		end else if (end_lt_start && !step_q[DW-1]) begin
			chk_code = irsg_pkg::ST_EMPTY;
		end else if (start_lt_end && step_q[DW-1]) begin
			chk_code = irsg_pkg::ST_EMPTY;
		end else begin
			chk_special = 1'b0;
		end
		diff = end_lt_start ? (start_q - end_q) : (end_q - start_q);
		mag  = step_q[DW-1] ? (DW'(0) - step_q) : step_q;
	end

	// Restoring divider step: one quotient bit per cycle
	assign trial     = {rem_q, quo_q[DW-1]};
	assign trial_sub = trial - {1'b0, mag_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			mag_q <= mag;
			rem_q <= '0;
			quo_q <= diff;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
			if (!trial_sub[DW]) begin
				rem_q <= trial_sub[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// Length: quotient plus one on remainder or inclusive bound
	always_comb begin
		q_big     = quo_q > DW'(MAX_LIST_LEN);
		len       = quo_q[LEN_W-1:0] + LEN_W'((rem_q != '0) || incl_q);
		len_big   = len > LEN_W'(MAX_LIST_LEN);
		eval_bad  = q_big || len_big || (len == '0);
		eval_code = (q_big || len_big) ? irsg_pkg::ST_TOO_LONG : irsg_pkg::ST_EMPTY;
	end

	// Element generator
	always_ff @(posedge clk) begin
		if (cmd.seq_load) begin
			cur_q  <= start_q;
			left_q <= len;
		end else if (cmd.push_elem) begin
			cur_q  <= cur_q + step_q;
			left_q <= left_q - LEN_W'(1);
		end
	end

	// Status to the controller
	always_comb begin
		sts.out_free    = !ov_q || out_ready;
		sts.chk_special = chk_special;
		sts.chk_code    = chk_code;
		sts.div_done    = (cnt_q == CW'(DW - 1));
		sts.eval_bad    = eval_bad;
		sts.eval_code   = eval_code;
		sts.elem_last   = (left_q == LEN_W'(1));
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.push_elem || cmd.push_stat) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_elem) begin
			elem_q <= cur_q;
			stat_q <= irsg_pkg::ST_ELEMENT;
			last_q <= sts.elem_last;
		end else if (cmd.push_stat) begin
			elem_q <= '0;
			stat_q <= cmd.stat_code;
			last_q <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign element   = elem_q;
	assign status    = stat_q;
	assign last      = last_q;

endmodule

/* rtl/core/integer_range_sequence_generator_unit.sv */
// Channel  | Handshake            | Payload
// config   | cfg_we               | cfg_wdata (inclusive bound)
// in       | in_valid / in_ready  | start_val, end_val, step_val, any_null
// out      | out_valid / out_ready| element, status, last
//
// One request at a time. Null, zero-step and wrong-direction requests go from the
// check state straight to the output register; others run a radix-2 divider
// for the list length, then emit N results (N up to MAX_LIST_LEN), or one
// status result for a too-long or empty list.
// Output stalls hold the emitter; a new request is taken while a result waits.
// Reset (arst_n, asynchronous) clears the controller, output valid and the
// inclusive bound.
// Top level: joins irsg_ctrl and irsg_dp. Depends on irsg_pkg.
`timescale 1ns / 1ps

module integer_range_sequence_generator_unit #(
	parameter int unsigned MAX_LIST_LEN = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [irsg_pkg::DATA_W-1:0] start_val,
	input  logic signed [irsg_pkg::DATA_W-1:0] end_val,
	input  logic signed [irsg_pkg::DATA_W-1:0] step_val,
	input  logic                               any_null,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [irsg_pkg::DATA_W-1:0] element,
	output logic [1:0]                         status,
	output logic                               last
);

	irsg_pkg::cmd_t cmd;
	irsg_pkg::sts_t sts;

	irsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	irsg_dp #(
		.MAX_LIST_LEN (MAX_LIST_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start_val (start_val),
		.end_val   (end_val),
		.step_val  (step_val),
		.any_null  (any_null),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.element   (element),
		.status    (status),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* rtl/core/irsg_chk.sv */
// Port-level checker for the range generator, bound to the top level.
// Depends on irsg_pkg (status codes).
`timescale 1ns / 1ps

module irsg_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [irsg_pkg::DATA_W-1:0] element,
	input logic [1:0]                         status,
	input logic                               last
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element) && $stable(status)
			&& $stable(last))
		else $error("output changed while stalled");

	// Status-only results close their request
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != irsg_pkg::ST_ELEMENT) |-> last)
		else $error("status result without last");

	// Status-only results carry a zero element
	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != irsg_pkg::ST_ELEMENT) |-> (element == '0))
		else $error("status result with nonzero element");

	// One request at a time: ready drops after a request is taken
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

endmodule

bind integer_range_sequence_generator_unit irsg_chk u_irsg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.element   (element),
	.status    (status),
	.last      (last)
);
